// ===== sv/fstc_pkg.sv =====
// shared types and constants for the framed set time command parser
package fstc_pkg;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_FUNC   = 3'd1,
    ST_BAD_OPT    = 3'd2,
    ST_NOT_NUMBER = 3'd3,
    ST_ZERO       = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    STAGE_FUNC = 2'd0,
    STAGE_OPT  = 2'd1,
    STAGE_NUM  = 2'd2,
    STAGE_DONE = 2'd3
  } stage_t;

  typedef enum logic {
    REG_START_CHAR = 1'b0,
    REG_END_CHAR   = 1'b1
  } reg_index_t;

  localparam logic [7:0] START_CHAR_RESET = 8'd36;
  localparam logic [7:0] END_CHAR_RESET   = 8'd13;
  localparam logic [7:0] CHAR_SPACE       = 8'd32;
  localparam logic [7:0] CHAR_DIGIT_LO    = 8'd48;
  localparam logic [7:0] CHAR_DIGIT_HI    = 8'd57;
  localparam logic [2:0] FUNC_LEN         = 3'd3;
  localparam logic [2:0] OPT_LEN          = 3'd4;
  localparam logic [2:0] POS_MAX          = 3'd7;

  // letter of "set" at a word position, zero past the end
  function automatic logic [7:0] func_kw(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = 8'h73;
      3'd1:    ch = 8'h65;
      3'd2:    ch = 8'h74;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // letter of "time" at a word position, zero past the end
  function automatic logic [7:0] opt_kw(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = 8'h74;
      3'd1:    ch = 8'h69;
      3'd2:    ch = 8'h6d;
      3'd3:    ch = 8'h65;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ===== sv/framed_set_time_command_parser.sv =====
// framed "set time" command parser, one received byte per beat
// a byte ending a frame passes the input register at its accept, then the result
// register when the parse state advances on it
// throughput: one byte per cycle, set by the single parse state update per byte
// while the result register is full and not taken, the input stage holds
// reset: synchronous, clears the frame state and restores start '$' and end CR
module framed_set_time_command_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [2:0] status, [10:3] seconds, [15:11] zero
);

  import fstc_pkg::*;

  logic [7:0] start_char;
  logic [7:0] end_char;

  logic       in_valid;
  logic [7:0] in_byte;

  logic       in_frame, in_frame_next;
  stage_t     parse_stage, parse_stage_next;
  logic [2:0] word_position, word_position_next;
  logic       word_matches, word_matches_next;
  status_t    error_code, error_code_next;
  logic [7:0] value_accumulator, value_accumulator_next;

  logic       out_valid;
  status_t    out_status;
  logic [7:0] out_seconds;

  logic       advance;
  logic       res_valid;
  status_t    res_status;
  logic [7:0] res_seconds;

  // word close results
  stage_t     ew_stage;
  status_t    ew_error;
  logic [7:0] kw_ch;
  logic [2:0] kw_len;
  logic [7:0] digit;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'd0, out_seconds, out_status};
  assign digit         = in_byte - CHAR_DIGIT_LO;

  // effect of a space or end byte on the current word
  always_comb begin
    ew_stage = parse_stage;
    ew_error = error_code;
    case (parse_stage)
      STAGE_FUNC: begin
        if (word_matches && word_position == FUNC_LEN) begin
          ew_stage = STAGE_OPT;
        end else begin
          ew_stage = STAGE_DONE;
          ew_error = ST_BAD_FUNC;
        end
      end
      STAGE_OPT: begin
        if (word_matches && word_position == OPT_LEN) begin
          ew_stage = STAGE_NUM;
        end else begin
          ew_stage = STAGE_DONE;
          ew_error = ST_BAD_OPT;
        end
      end
      default: ew_stage = STAGE_DONE;
    endcase
  end

  always_comb begin
    if (parse_stage == STAGE_FUNC) begin
      kw_ch  = func_kw(word_position);
      kw_len = FUNC_LEN;
    end else begin
      kw_ch  = opt_kw(word_position);
      kw_len = OPT_LEN;
    end
  end

  always_comb begin
    in_frame_next          = in_frame;
    parse_stage_next       = parse_stage;
    word_position_next     = word_position;
    word_matches_next      = word_matches;
    error_code_next        = error_code;
    value_accumulator_next = value_accumulator;
    res_valid              = 1'b0;
    res_status             = ST_OK;
    res_seconds            = 8'd0;

    if (in_byte == start_char || (in_frame && in_byte == end_char)) begin
      // frame opens, reopens or closes: parse state starts over
      in_frame_next          = (in_byte == start_char);
      parse_stage_next       = STAGE_FUNC;
      word_position_next     = 3'd0;
      word_matches_next      = 1'b1;
      error_code_next        = ST_OK;
      value_accumulator_next = 8'd0;
      if (in_byte != start_char) begin
        res_valid = 1'b1;
        if (error_code != ST_OK) begin
          res_status = error_code;
        end else if (parse_stage != STAGE_DONE && ew_error != ST_OK) begin
          res_status = ew_error;
        end else if (parse_stage != STAGE_DONE && ew_stage == STAGE_OPT) begin
          res_status = ST_BAD_OPT;
        end else if (value_accumulator == 8'd0) begin
          res_status = ST_ZERO;
        end else begin
          res_status  = ST_OK;
          res_seconds = value_accumulator;
        end
      end
    end else if (in_frame && parse_stage != STAGE_DONE) begin
      if (in_byte == CHAR_SPACE) begin
        parse_stage_next   = ew_stage;
        error_code_next    = ew_error;
        word_position_next = 3'd0;
        word_matches_next  = 1'b1;
      end else if (parse_stage == STAGE_NUM) begin
        if (in_byte < CHAR_DIGIT_LO || in_byte > CHAR_DIGIT_HI) begin
          error_code_next  = ST_NOT_NUMBER;
          parse_stage_next = STAGE_DONE;
        end else begin
          value_accumulator_next = {value_accumulator[4:0], 3'd0}
                                 + {value_accumulator[6:0], 1'b0} + digit;
        end
      end else begin
        if (word_position >= kw_len || kw_ch != in_byte) begin
          word_matches_next = 1'b0;
        end
        if (word_position < POS_MAX) begin
          word_position_next = word_position + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_char        <= START_CHAR_RESET;
      end_char          <= END_CHAR_RESET;
      in_valid          <= 1'b0;
      out_valid         <= 1'b0;
      in_frame          <= 1'b0;
      parse_stage       <= STAGE_FUNC;
      word_position     <= 3'd0;
      word_matches      <= 1'b1;
      error_code        <= ST_OK;
      value_accumulator <= 8'd0;
    end else begin
      if (cfg_we) begin
        case (reg_index_t'(cfg_index))
          REG_START_CHAR: start_char <= cfg_data;
          REG_END_CHAR:   end_char   <= cfg_data;
          default:        start_char <= start_char;
        endcase
      end
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (advance && res_valid) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (advance) begin
        in_frame          <= in_frame_next;
        parse_stage       <= parse_stage_next;
        word_position     <= word_position_next;
        word_matches      <= word_matches_next;
        error_code        <= error_code_next;
        value_accumulator <= value_accumulator_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
    end
    if (advance && res_valid) begin
      out_status  <= res_status;
      out_seconds <= res_seconds;
    end
  end

endmodule

// ===== verif/tb_framed_set_time_command_parser.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the framed set time command parser
module tb_framed_set_time_command_parser;
  import fstc_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_BYTES = 1000;
  localparam logic [23:0] SET_WORD  = "set";
  localparam logic [31:0] TIME_WORD = "time";

  typedef struct packed {
    status_t    status;
    logic [7:0] seconds;
  } command_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [7:0]  cfg_data = 8'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  framed_set_time_command_parser dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk = ~clk;

  command_result_t pending_results[$];
  int error_count = 0;
  int cycle_count = 0;
  int bytes_sent = 0;

  // stimulus-side frame characters
  logic [7:0] cur_start = START_CHAR_RESET;
  logic [7:0] cur_end   = END_CHAR_RESET;

  bit src_idle_on  = 1'b0;
  bit sink_idle_on = 1'b0;
  int stall_request = 0;

  // parser shadow state
  logic [7:0] start_ch, end_ch;
  logic       frame_open;
  stage_t     stage;
  logic [2:0] word_len;
  logic       word_ok;
  status_t    first_err;
  logic [7:0] number_acc;

  task automatic clear_parse();
    stage      = STAGE_FUNC;
    word_len   = 3'd0;
    word_ok    = 1'b1;
    first_err  = ST_OK;
    number_acc = 8'd0;
  endtask

  task automatic close_word();
    if (stage == STAGE_FUNC) begin
      if (word_ok && word_len == 3'd3) begin
        stage = STAGE_OPT;
      end else begin
        first_err = ST_BAD_FUNC;
        stage     = STAGE_DONE;
      end
    end else if (stage == STAGE_OPT) begin
      if (word_ok && word_len == 3'd4) begin
        stage = STAGE_NUM;
      end else begin
        first_err = ST_BAD_OPT;
        stage     = STAGE_DONE;
      end
    end else begin
      stage = STAGE_DONE;
    end
    word_len = 3'd0;
    word_ok  = 1'b1;
  endtask

  task automatic match_letter(input logic [7:0] c);
    logic [7:0] want;
    want = 8'h00;
    if (stage == STAGE_FUNC) begin
      if (word_len < 3'd3) want = SET_WORD[8 * (2 - word_len) +: 8];
      else word_ok = 1'b0;
    end else begin
      if (word_len < 3'd4) want = TIME_WORD[8 * (3 - word_len) +: 8];
      else word_ok = 1'b0;
    end
    if (want != c) word_ok = 1'b0;
    if (word_len != 3'd7) word_len = word_len + 3'd1;
  endtask

  task automatic parse_byte(input logic [7:0] c);
    command_result_t res;
    if (c == start_ch) begin
      frame_open = 1'b1;
      clear_parse();
    end else if (frame_open) begin
      if (c == end_ch) begin
        if (stage != STAGE_DONE) close_word();
        if (first_err != ST_OK) res.status = first_err;
        else if (stage == STAGE_OPT) res.status = ST_BAD_OPT;
        else if (number_acc == 8'd0) res.status = ST_ZERO;
        else res.status = ST_OK;
        res.seconds = (res.status == ST_OK) ? number_acc : 8'd0;
        pending_results.push_back(res);
        frame_open = 1'b0;
        clear_parse();
      end else if (stage != STAGE_DONE) begin
        if (c == CHAR_SPACE) begin
          close_word();
        end else if (stage == STAGE_NUM) begin
          if (c < CHAR_DIGIT_LO || c > CHAR_DIGIT_HI) begin
            first_err = ST_NOT_NUMBER;
            stage     = STAGE_DONE;
          end else begin
            number_acc = number_acc * 8'd10 + (c - CHAR_DIGIT_LO);
          end
        end else begin
          match_letter(c);
        end
      end
    end
  endtask

  // predicts on accepted bytes, tracks register writes
  always @(posedge clk) begin
    if (rst) begin
      start_ch   = START_CHAR_RESET;
      end_ch     = END_CHAR_RESET;
      frame_open = 1'b0;
      clear_parse();
    end else begin
      if (s_axis_tvalid && s_axis_tready) parse_byte(s_axis_tdata);
      if (cfg_we) begin
        case (cfg_index)
          REG_START_CHAR: start_ch = cfg_data;
          REG_END_CHAR:   end_ch   = cfg_data;
          default: ;
        endcase
      end
    end
  end

  // compares each result beat against the oldest prediction
  always @(posedge clk) begin : result_check
    command_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: status %0d seconds %0d",
               m_axis_tdata[2:0], m_axis_tdata[10:3]);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[2:0] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tdata[2:0]);
          error_count++;
        end
        if (m_axis_tdata[10:3] !== want.seconds) begin
          $error("seconds: expected %0d, got %0d", want.seconds, m_axis_tdata[10:3]);
          error_count++;
        end
      end
    end
  end

  // output ready: long holds on request, random stalls when enabled
  always @(posedge clk) begin : sink_ctl
    int stall_left;
    int pause_left;
    int r;
    if (stall_request != 0) begin
      stall_left    = stall_request;
      stall_request = 0;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (!sink_idle_on) begin
      m_axis_tready <= 1'b1;
    end else if (pause_left > 0) begin
      pause_left--;
      m_axis_tready <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        m_axis_tready <= 1'b1;
      end else begin
        pause_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(8, 40);
        m_axis_tready <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[framed_set_time_command_parser] ERROR");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    int r;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    bytes_sent++;
    gap = 0;
    if (src_idle_on) begin
      r = $urandom_range(0, 99);
      if (r >= 93) gap = $urandom_range(10, 30);
      else if (r >= 65) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_text(input string t);
    for (int i = 0; i < t.len(); i++) send_byte(t[i]);
  endtask

  task automatic send_frame(input string body);
    send_byte(cur_start);
    send_text(body);
    send_byte(cur_end);
  endtask

  // stop offering beats until every predicted result is out
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    // let the predictor see the last accepted beat first
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    // bytes without a result may still sit in the input stage
    repeat (4) @(posedge clk);
  endtask

  task automatic set_frame_chars(input logic [7:0] s, input logic [7:0] e);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_START_CHAR;
    cfg_data  <= s;
    @(posedge clk);
    cfg_index <= REG_END_CHAR;
    cfg_data  <= e;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_start = s;
    cur_end   = e;
  endtask

  // mostly the keyword, with dropped, swapped or extra letters
  task automatic send_word_variant(input string keyword);
    int n;
    n = $urandom_range(0, 9);
    for (int i = 0; i < n; i++) begin
      if (i < keyword.len() && $urandom_range(0, 3) != 0) send_byte(keyword[i]);
      else send_byte(8'(8'h61 + $urandom_range(0, 25)));
    end
  endtask

  task automatic send_random_frame();
    int r;
    int digits;
    send_byte(cur_start);
    if ($urandom_range(0, 99) < 85) send_text("set");
    else send_word_variant("set");
    send_byte(CHAR_SPACE);
    if ($urandom_range(0, 99) < 8) send_byte(CHAR_SPACE);
    if ($urandom_range(0, 99) < 85) send_text("time");
    else send_word_variant("time");
    send_byte(CHAR_SPACE);
    if ($urandom_range(0, 99) < 5) send_byte(CHAR_SPACE);
    r = $urandom_range(0, 99);
    digits = (r < 5) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(4, 8);
    for (int i = 0; i < digits; i++) begin
      if ($urandom_range(0, 99) < 4) send_byte(8'($urandom_range(0, 255)));
      else send_byte(8'(CHAR_DIGIT_LO + $urandom_range(0, 9)));
    end
    if ($urandom_range(0, 99) < 15) send_text(" now 12");
    r = $urandom_range(0, 99);
    if (r < 92) send_byte(cur_end);
    else if (r < 96) send_byte(8'($urandom_range(0, 255)));
    // otherwise the next start beat restarts the open frame
  endtask

  task automatic test_directed_frames();
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    send_frame("set time 5");
    send_frame("set time 255");
    send_frame("set time 256");
    send_frame("set time 0");
    send_frame("set time 007");
    send_frame("get time 1");
    send_frame("set date 1");
    send_frame("set time 1x");
    send_frame("set  time 1");
    send_frame(" set time 1");
    send_frame("setsetsetset time 1");
    send_frame("set");
    send_frame("set time");
    send_frame("set time 99 ");
    send_frame("set time 12 and more");
    send_frame("");
    // start beat inside a frame drops the partial one
    send_text("$set ti");
    send_frame("set time 9");
    // bytes outside any frame are dropped
    send_text("set time 3\r");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(cur_start);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(cur_end);
  endtask

  task automatic test_frame_chars();
    set_frame_chars(8'h00, 8'hFF);
    send_frame("set time 77");
    send_frame("set tim 1");
    set_frame_chars(8'hFF, 8'h00);
    send_frame("set time 3");
    send_text("set\r$");
    // identical start and end: no frame ever closes
    set_frame_chars(8'h41, 8'h41);
    send_frame("set time 4");
    send_text("set time 5");
    set_frame_chars(START_CHAR_RESET, END_CHAR_RESET);
    send_frame("set time 6");
  endtask

  task automatic test_output_stall();
    wait_idle();
    src_idle_on  = 1'b0;
    stall_request = 400;
    for (int i = 1; i <= 10; i++) send_frame($sformatf("set time %0d", i * 23));
    wait_idle();
  endtask

  task automatic test_random_traffic();
    logic [7:0] s, e;
    int seg_end;
    for (int seg = 0; seg < 4; seg++) begin
      if (seg == 1 || seg == 3) begin
        do begin
          s = 8'($urandom_range(0, 255));
          e = 8'($urandom_range(0, 255));
        end while (s == e);
        set_frame_chars(s, e);
      end else if (seg == 2) begin
        set_frame_chars("#", 8'h0A);
      end
      src_idle_on  = (seg != 0);
      sink_idle_on = (seg != 0);
      seg_end = bytes_sent + RANDOM_BYTES / 4;
      while (bytes_sent < seg_end) begin
        if ($urandom_range(0, 99) < 20) begin
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        end
        send_random_frame();
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed_frames();
    test_frame_chars();
    test_output_stall();
    test_random_traffic();
    wait_idle();
    if (error_count == 0) begin
      $display("[framed_set_time_command_parser] OK");
    end else begin
      $display("[framed_set_time_command_parser] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/fstc_pkg.sv
sv/framed_set_time_command_parser.sv
verif/tb_framed_set_time_command_parser.sv
